// ===== hdl/tbcs_pkg.sv =====
// ----------------------------------------------------------------------------
// tbcs_pkg
// Shared types and constants for the barycentric triangle color shader.
// ----------------------------------------------------------------------------
package tbcs_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int PIX_W          = 12;
    localparam int CFG_W          = 24;
    localparam int CFG_IDX_W      = 3;
    localparam int CHAN_W         = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_VERTEX_ONE   = 3'd0,
        CFG_VERTEX_TWO   = 3'd1,
        CFG_VERTEX_THREE = 3'd2,
        CFG_COLOR_ONE    = 3'd3,
        CFG_COLOR_TWO    = 3'd4,
        CFG_COLOR_THREE  = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_y;
        logic [PIX_W-1:0] pixel_x;
    } t_pix_in;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } t_color_out;

endpackage

// ===== hdl/triangle_barycentric_color_shader.sv =====
// ----------------------------------------------------------------------------
// triangle_barycentric_color_shader
// Shades one pixel per beat by barycentric blend of three vertex colors.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one pixel
//   coordinate per beat. Output channel (o_out_valid / i_out_ready /
//   o_out_data) returns red, green and blue for that pixel in one beat.
//   Config port: i_cfg_we writes i_cfg_data[23:0] to register i_cfg_idx
//   (vertices 0..2, colors 3..5); other indexes are dropped. Write only
//   while the pipe is empty.
//   Throughput: one pixel per clock while the output is not stalled,
//   through the 8-stage pipe: diffs, products, cross and abs, weighted
//   sums, then a 4-stage divider taking 2 quotient bits each.
//   Reset clears all valid bits and the config registers.
//   Stall: each stage holds when its successor is full and stalled, so
//   bubbles collapse; input ready drops only when the whole pipe is full.
//   Outside pixels and degenerate triangles give black.
// ----------------------------------------------------------------------------
module triangle_barycentric_color_shader #(
    parameter int COORD_BITS = tbcs_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  tbcs_pkg::t_pix_in             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output tbcs_pkg::t_color_out          o_out_data,
    input  logic                          i_cfg_we,
    input  logic [tbcs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tbcs_pkg::CFG_W-1:0]    i_cfg_data
);
    localparam int C   = COORD_BITS;
    localparam int DW  = 2*C + 3;      // signed cross product
    localparam int SW  = DW + 2;       // sum of three weights
    localparam int NW  = SW + tbcs_pkg::CHAN_W; // weighted color sum
    localparam int CW  = tbcs_pkg::CHAN_W;
    localparam int NST = 8;

    // config registers
    logic [tbcs_pkg::CFG_W-1:0] r_vtx [3];
    logic [tbcs_pkg::CFG_W-1:0] r_col [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_vtx[i] <= '0;
                r_col[i] <= '0;
            end
        end else if (i_cfg_we) begin
            case (tbcs_pkg::t_cfg_idx'(i_cfg_idx))
                tbcs_pkg::CFG_VERTEX_ONE:   r_vtx[0] <= i_cfg_data;
                tbcs_pkg::CFG_VERTEX_TWO:   r_vtx[1] <= i_cfg_data;
                tbcs_pkg::CFG_VERTEX_THREE: r_vtx[2] <= i_cfg_data;
                tbcs_pkg::CFG_COLOR_ONE:    r_col[0] <= i_cfg_data;
                tbcs_pkg::CFG_COLOR_TWO:    r_col[1] <= i_cfg_data;
                tbcs_pkg::CFG_COLOR_THREE:  r_col[2] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // vertex coordinates, zero-extended so y above bit 23 reads as 0
    logic [C-1:0] w_vx [3];
    logic [C-1:0] w_vy [3];
    logic [C-1:0] w_px, w_py;
    always_comb begin
        logic [2*C+tbcs_pkg::CFG_W-1:0] ext;
        for (int i = 0; i < 3; i++) begin
            ext     = (2*C+tbcs_pkg::CFG_W)'(r_vtx[i]);
            w_vx[i] = ext[C-1:0];
            w_vy[i] = ext[2*C-1:C];
        end
    end
    always_comb begin
        logic [C+tbcs_pkg::PIX_W-1:0] ex, ey;
        ex   = (C+tbcs_pkg::PIX_W)'(i_in_data.pixel_x);
        ey   = (C+tbcs_pkg::PIX_W)'(i_in_data.pixel_y);
        w_px = ex[C-1:0];
        w_py = ey[C-1:0];
    end

    // valid bits and per-stage advance
    logic [NST-1:0] r_v;
    logic [NST-1:0] w_en;
    always_comb begin
        w_en[NST-1] = !r_v[NST-1] || i_out_ready;
        for (int k = NST-2; k >= 0; k--)
            w_en[k] = !r_v[k] || w_en[k+1];
    end
    assign o_in_ready  = w_en[0];
    assign o_out_valid = r_v[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) r_v[0] <= i_in_valid;
            for (int k = 1; k < NST; k++)
                if (w_en[k]) r_v[k] <= r_v[k-1];
        end
    end

    // Stage 0: coordinate differences. Edge e of (p, a, b) is
    // (p.x-b.x)*(a.y-b.y) - (a.x-b.x)*(p.y-b.y); edges (p,v0,v1),
    // (p,v1,v2), (p,v2,v0).
    logic signed [C:0] r0_d [3][4];
    always_ff @(posedge i_clk) begin
        int ia, ib;
        if (w_en[0]) begin
            for (int e = 0; e < 3; e++) begin
                ia = e;
                ib = (e + 1) % 3;
                r0_d[e][0] <= $signed({1'b0, w_px})      - $signed({1'b0, w_vx[ib]});
                r0_d[e][1] <= $signed({1'b0, w_vy[ia]}) - $signed({1'b0, w_vy[ib]});
                r0_d[e][2] <= $signed({1'b0, w_vx[ia]}) - $signed({1'b0, w_vx[ib]});
                r0_d[e][3] <= $signed({1'b0, w_py})      - $signed({1'b0, w_vy[ib]});
            end
        end
    end

    // Stage 1: products
    logic signed [2*C+1:0] r1_pa [3];
    logic signed [2*C+1:0] r1_pb [3];
    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int e = 0; e < 3; e++) begin
                r1_pa[e] <= r0_d[e][0] * r0_d[e][1];
                r1_pb[e] <= r0_d[e][2] * r0_d[e][3];
            end
        end
    end

    // Stage 2: cross, coverage, weights. w0=|e1|, w1=|e2|, w2=|e0|.
    logic [DW-1:0] r2_w [3];
    logic          r2_in;
    always_ff @(posedge i_clk) begin
        logic signed [DW-1:0] cr [3];
        if (w_en[2]) begin
            for (int e = 0; e < 3; e++)
                cr[e] = DW'(r1_pa[e]) - DW'(r1_pb[e]);
            r2_in <= (cr[0][DW-1] == cr[1][DW-1]) && (cr[1][DW-1] == cr[2][DW-1]);
            for (int e = 0; e < 3; e++)
                r2_w[(e + 2) % 3] <= cr[e][DW-1] ? DW'(-cr[e]) : DW'(cr[e]);
        end
    end

    // Stage 3: denominator and per-channel numerators
    logic [SW-1:0] r3_den;
    logic [NW-1:0] r3_num [3];
    logic          r3_blk;
    always_ff @(posedge i_clk) begin
        logic [SW-1:0] den;
        if (w_en[3]) begin
            den = SW'(r2_w[0]) + SW'(r2_w[1]) + SW'(r2_w[2]);
            r3_den <= den;
            r3_blk <= !r2_in || (den == '0);
            for (int ch = 0; ch < 3; ch++)
                r3_num[ch] <= NW'(r_col[0][CW*ch +: CW] * r2_w[0])
                            + NW'(r_col[1][CW*ch +: CW] * r2_w[1])
                            + NW'(r_col[2][CW*ch +: CW] * r2_w[2]);
        end
    end

    // Stages 4..7: restoring divide, two quotient bits per stage
    logic [NW-1:0] r_rem [4][3];
    logic [CW-1:0] r_q   [4][3];
    logic [SW-1:0] r_dd  [4];
    logic          r_blk [4];

    for (genvar s = 0; s < 4; s++) begin : g_div
        always_ff @(posedge i_clk) begin
            logic [NW-1:0] rem;
            logic [CW-1:0] q;
            logic [NW-1:0] sh;
            if (w_en[4+s]) begin
                r_dd[s]  <= (s == 0) ? r3_den : r_dd[(s == 0) ? 0 : s-1];
                r_blk[s] <= (s == 0) ? r3_blk : r_blk[(s == 0) ? 0 : s-1];
                for (int ch = 0; ch < 3; ch++) begin
                    rem = (s == 0) ? r3_num[ch] : r_rem[(s == 0) ? 0 : s-1][ch];
                    q   = (s == 0) ? '0 : r_q[(s == 0) ? 0 : s-1][ch];
                    for (int b = 0; b < 2; b++) begin
                        sh = NW'((s == 0) ? r3_den : r_dd[(s == 0) ? 0 : s-1])
                             << (CW - 1 - 2*s - b);
                        if (rem >= sh) begin
                            rem = rem - sh;
                            q[CW-1-2*s-b] = 1'b1;
                        end
                    end
                    r_rem[s][ch] <= rem;
                    r_q[s][ch]   <= q;
                end
            end
        end
    end

    assign o_out_data.blue  = r_blk[3] ? '0 : r_q[3][0];
    assign o_out_data.green = r_blk[3] ? '0 : r_q[3][1];
    assign o_out_data.red   = r_blk[3] ? '0 : r_q[3][2];

endmodule

// ===== hdl/tbcs_chk.sv =====
// ----------------------------------------------------------------------------
// tbcs_chk
// Port-level checks for the triangle color shader, bound to the top level.
// ----------------------------------------------------------------------------
module tbcs_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input tbcs_pkg::t_color_out o_out_data
);
    // empty pipe right after reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // with nothing at the output, no stage can be blocked
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready with empty output");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped under stall");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_data))
        else $error("output beat changed under stall");
endmodule

bind triangle_barycentric_color_shader tbcs_chk u_tbcs_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
